FILE: design/htwd_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
package htwd_pkg;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam int ENTRY_W  = 9;
  localparam int LEAF_BIT = 8;
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef struct packed {
    logic       operation;
    logic [7:0] node_index;
    logic       branch;
    logic       child_is_leaf;
    logic [7:0] child_value;
    logic [7:0] data_byte;
    logic [3:0] bit_count;
  } in_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } out_t;

  // Tree table read request from the walker: node and branch of the next step.
  typedef struct packed {
    logic [7:0] node;
    logic       side;
  } read_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

endpackage

FILE: design/huffman_tree_walk_decoder.sv
// Top level: tree table RAM, load path and the bit-walk sequencer.
//
//  channel   ports                        transfer when
//  command   start, busy, command         start && !busy
//  result    result_valid, result         result_valid (one cycle, no stall)
//
// A load leaves busy low. A decode with n valid bits
// (0 or more than 8 count as 8) holds busy after the transfer while it
// makes one tree table read per bit through the RAM read port (ST_WALK),
// then releases the held-back final symbol with last set (ST_FLUSH).
// Symbols appear in the cycle after the leaf that follows them is reached.
// rst is synchronous and returns the walk to the root; table contents stay.
module huffman_tree_walk_decoder #(
  parameter int SYMBOLS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  htwd_pkg::in_t  command,
  output logic           result_valid,
  output htwd_pkg::out_t result
);

  localparam int DEPTH = 2 * (SYMBOLS - 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [7:0] NODES = 8'(SYMBOLS - 1);

  logic                        accept;
  logic                        we;
  logic [8:0]                  wslot;
  logic [8:0]                  rslot;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;
  logic [htwd_pkg::ENTRY_W-1:0] wdata;
  logic [htwd_pkg::ENTRY_W-1:0] rdata;
  logic [htwd_pkg::ENTRY_W-1:0] entry;
  logic                        oob;
  htwd_pkg::read_req_t         rd;

  assign accept = start && !busy;
  assign we     = accept && (command.operation == htwd_pkg::OP_LOAD) &&
                  (command.node_index < NODES);
  assign wslot  = {command.node_index, command.branch};
  assign waddr  = wslot[AW-1:0];
  assign wdata  = {command.child_is_leaf, command.child_value};
  assign rslot  = {rd.node, rd.side};
  assign raddr  = rslot[AW-1:0];

  // nodes past the table read as an internal child pointing at the root
  always_ff @(posedge clk) begin
    if (rst) begin
      oob <= 1'b0;
    end else begin
      oob <= !(rd.node < NODES);
    end
  end

  assign entry = oob ? '0 : rdata;

  htwd_ram #(
    .WIDTH(htwd_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  htwd_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .start_decode(accept && (command.operation == htwd_pkg::OP_DECODE)),
    .data_byte   (command.data_byte),
    .bit_count   (command.bit_count),
    .entry       (entry),
    .rd          (rd),
    .busy        (busy),
    .result      (result),
    .result_valid(result_valid)
  );

endmodule

FILE: design/htwd_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module htwd_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 510
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/htwd_walker.sv
// Bit sequencer: one tree step per cycle, symbol hold-back for the last flag.
module htwd_walker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start_decode,
  input  logic [7:0]                data_byte,
  input  logic [3:0]                bit_count,
  input  logic [htwd_pkg::ENTRY_W-1:0] entry,
  output htwd_pkg::read_req_t       rd,
  output logic                      busy,
  output htwd_pkg::out_t            result,
  output logic                      result_valid
);

  htwd_pkg::state_t state, state_next;
  logic [7:0] node, node_next;
  logic [7:0] bits, bits_next;
  logic [3:0] remaining, remaining_next;
  logic       pend_valid, pend_valid_next;
  logic [7:0] pend_sym, pend_sym_next;
  htwd_pkg::out_t result_next;
  logic       result_valid_next;

  logic       is_leaf;
  logic [7:0] step_node;
  logic [3:0] count;

  assign is_leaf   = entry[htwd_pkg::LEAF_BIT];
  assign step_node = is_leaf ? 8'd0 : entry[7:0];
  assign count     = (bit_count == 4'd0 || bit_count > htwd_pkg::BYTE_BITS) ?
                     htwd_pkg::BYTE_BITS : bit_count;
  assign busy      = (state != htwd_pkg::ST_IDLE);

  always_comb begin
    state_next        = state;
    node_next         = node;
    bits_next         = bits;
    remaining_next    = remaining;
    pend_valid_next   = pend_valid;
    pend_sym_next     = pend_sym;
    result_next       = result;
    result_valid_next = 1'b0;
    rd.node           = node;
    rd.side           = data_byte[7];
    case (state)
      htwd_pkg::ST_IDLE: begin
        if (start_decode) begin
          bits_next      = {data_byte[6:0], 1'b0};
          remaining_next = count;
          state_next     = htwd_pkg::ST_WALK;
        end
      end
      htwd_pkg::ST_WALK: begin
        // next address comes straight from this cycle's table data
        rd.node        = step_node;
        rd.side        = bits[7];
        node_next      = step_node;
        bits_next      = {bits[6:0], 1'b0};
        remaining_next = remaining - 4'd1;
        if (is_leaf) begin
          if (pend_valid) begin
            result_next.symbol = pend_sym;
            result_next.last   = 1'b0;
            result_valid_next  = 1'b1;
          end
          pend_valid_next = 1'b1;
          pend_sym_next   = entry[7:0];
        end
        if (remaining == 4'd1) begin
          state_next = htwd_pkg::ST_FLUSH;
        end
      end
      htwd_pkg::ST_FLUSH: begin
        if (pend_valid) begin
          result_next.symbol = pend_sym;
          result_next.last   = 1'b1;
          result_valid_next  = 1'b1;
        end
        pend_valid_next = 1'b0;
        state_next      = htwd_pkg::ST_IDLE;
      end
      default: begin
        state_next = htwd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= htwd_pkg::ST_IDLE;
      node         <= 8'd0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      node         <= node_next;
      pend_valid   <= pend_valid_next;
      result_valid <= result_valid_next;
    end
    bits      <= bits_next;
    remaining <= remaining_next;
    pend_sym  <= pend_sym_next;
    result    <= result_next;
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Huffman tree-walk decoder: directed trees, random trees.
module tb_top;

  localparam int SYMBOLS      = 256;
  localparam int INNER_NODES  = SYMBOLS - 1;
  localparam int TABLE_DEPTH  = 2 * INNER_NODES;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 130;
  localparam logic LEFT  = 1'b0;
  localparam logic RIGHT = 1'b1;
  localparam logic [7:0] OFF_TABLE_NODE = 8'd255;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  htwd_pkg::in_t  command;
  logic           result_valid;
  htwd_pkg::out_t result;

  huffman_tree_walk_decoder #(.SYMBOLS(SYMBOLS)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .result_valid (result_valid),
    .result       (result)
  );

  // Shadow copy of the code tree and the walk position.
  logic [htwd_pkg::ENTRY_W-1:0] code_tree [0:TABLE_DEPTH-1];
  logic [7:0]                   walk_node;
  htwd_pkg::out_t               pending_symbols[$];
  htwd_pkg::out_t               oldest_symbol;
  // Internal nodes of the last random tree; all of them have both children written.
  logic [7:0]                   tree_nodes[$];
  int                           error_count = 0;
  int                           items_sent  = 0;
  int                           cycle_count = 0;
  bit                           gaps_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40)
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic logic [3:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return htwd_pkg::BYTE_BITS;
    if (roll < 8) return 4'($urandom_range(1, 7));
    if (roll == 8) return 4'd0;
    return 4'($urandom_range(9, 15));
  endfunction

  // Applies one accepted item to the shadow tree and queues the symbols it yields.
  function automatic void walk_predict(input htwd_pkg::in_t item);
    logic [7:0]                   bits;
    logic [3:0]                   count;
    logic [htwd_pkg::ENTRY_W-1:0] entry;
    logic                         side;
    logic [7:0]                   syms [0:7];
    int                           n;
    htwd_pkg::out_t               sym;
    if (item.operation == htwd_pkg::OP_LOAD) begin
      if (item.node_index < INNER_NODES)
        code_tree[{item.node_index, item.branch}] = {item.child_is_leaf, item.child_value};
      return;
    end
    n     = 0;
    bits  = item.data_byte;
    count = (item.bit_count == 4'd0 || item.bit_count > htwd_pkg::BYTE_BITS) ?
            htwd_pkg::BYTE_BITS : item.bit_count;
    for (int i = 0; i < count; i++) begin
      side  = bits[7];
      bits  = bits << 1;
      // nodes past the table read as an internal pointer to the root
      entry = (walk_node < INNER_NODES) ? code_tree[{walk_node, side}] : '0;
      if (entry[htwd_pkg::LEAF_BIT]) begin
        syms[n]   = entry[7:0];
        n++;
        walk_node = '0;
      end else begin
        walk_node = entry[7:0];
      end
    end
    for (int k = 0; k < n; k++) begin
      sym.symbol = syms[k];
      sym.last   = (k == n - 1);
      pending_symbols.insert(pending_symbols.size(), sym);
    end
  endfunction

  // Holds start high until the transfer; start stays high into the next item unless a random gap drops it.
  task automatic send_item(input htwd_pkg::in_t item);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    command <= item;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    walk_predict(item);
    if (item.operation == htwd_pkg::OP_DECODE || item.node_index < INNER_NODES)
      items_sent++;
  endtask

  task automatic load_entry(input logic [7:0] node, input logic side, input logic leaf,
                            input logic [7:0] value);
    logic [31:0]   r;
    htwd_pkg::in_t item;
    r                  = $urandom;
    item               = r[$bits(htwd_pkg::in_t)-1:0];
    item.operation     = htwd_pkg::OP_LOAD;
    item.node_index    = node;
    item.branch        = side;
    item.child_is_leaf = leaf;
    item.child_value   = value;
    send_item(item);
  endtask

  task automatic decode_byte(input logic [7:0] data, input logic [3:0] count);
    logic [31:0]   r;
    htwd_pkg::in_t item;
    r              = $urandom;
    item           = r[$bits(htwd_pkg::in_t)-1:0];
    item.operation = htwd_pkg::OP_DECODE;
    item.data_byte = data;
    item.bit_count = count;
    send_item(item);
  endtask

  // Random tree on random node indices; every internal node gets both children.
  task automatic load_random_tree(input int inner_count);
    logic [8:0] open_slots[$];
    logic [8:0] slot;
    logic [7:0] pick;
    bit         taken;
    int         idx;
    int unsigned roll;
    tree_nodes.delete();
    tree_nodes.insert(0, 8'd0);
    while (tree_nodes.size() < inner_count) begin
      pick  = 8'($urandom_range(1, INNER_NODES - 1));
      taken = 1'b0;
      foreach (tree_nodes[k])
        if (tree_nodes[k] == pick) taken = 1'b1;
      if (!taken) tree_nodes.insert(tree_nodes.size(), pick);
    end
    open_slots.insert(open_slots.size(), {8'd0, LEFT});
    open_slots.insert(open_slots.size(), {8'd0, RIGHT});
    for (int j = 1; j < tree_nodes.size(); j++) begin
      idx  = $urandom_range(0, open_slots.size() - 1);
      slot = open_slots[idx];
      open_slots.delete(idx);
      load_entry(slot[8:1], slot[0], 1'b0, tree_nodes[j]);
      open_slots.insert(open_slots.size(), {tree_nodes[j], LEFT});
      open_slots.insert(open_slots.size(), {tree_nodes[j], RIGHT});
    end
    // first two open slots are always leaves so the tree has at least two
    for (int k = 0; k < open_slots.size(); k++) begin
      slot = open_slots[k];
      roll = $urandom_range(0, 15);
      if (k >= 2 && roll == 0)
        load_entry(slot[8:1], slot[0], 1'b0, OFF_TABLE_NODE);
      else if (k >= 2 && roll == 1)
        load_entry(slot[8:1], slot[0], 1'b0, 8'd0);
      else
        load_entry(slot[8:1], slot[0], 1'b1, rand_byte());
    end
  endtask

  // Load between decodes: dropped, leaf rewrite, or pointer to a complete node.
  task automatic stray_load();
    logic [31:0] r;
    logic [7:0]  node;
    logic [7:0]  target;
    r      = $urandom;
    node   = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
    target = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
    case ($urandom_range(0, 2))
      0: begin
        load_entry(OFF_TABLE_NODE, r[0], r[1], rand_byte());
      end
      1: begin
        load_entry(node, r[0], 1'b1, rand_byte());
      end
      default: begin
        load_entry(node, r[0], 1'b0, target);
      end
    endcase
  endtask

  // Root: left leaf 0x00, right to node 254; node 254: left leaf 0xFF, right off table.
  task automatic test_boundary_tree();
    load_entry(8'd0, LEFT, 1'b1, 8'h00);
    load_entry(8'd0, RIGHT, 1'b0, 8'd254);
    load_entry(8'd254, LEFT, 1'b1, 8'hFF);
    load_entry(8'd254, RIGHT, 1'b0, OFF_TABLE_NODE);
    load_entry(OFF_TABLE_NODE, LEFT, 1'b1, 8'hAA);
  endtask

  task automatic test_max_symbols_per_byte();
    decode_byte(8'h00, htwd_pkg::BYTE_BITS);
    decode_byte(8'h55, htwd_pkg::BYTE_BITS);
    decode_byte(8'h00, 4'd1);
  endtask

  task automatic test_beyond_table_walk();
    decode_byte(8'hFF, htwd_pkg::BYTE_BITS);
    load_entry(OFF_TABLE_NODE, RIGHT, 1'b0, 8'd0);
    decode_byte(8'h7F, htwd_pkg::BYTE_BITS);
    decode_byte(8'h00, htwd_pkg::BYTE_BITS);
  endtask

  task automatic test_bit_count_saturation();
    decode_byte(8'h80, 4'd0);
    decode_byte(rand_byte(), 4'd9);
    decode_byte(rand_byte(), 4'd12);
    decode_byte(rand_byte(), 4'd15);
    decode_byte(8'h80, 4'd1);
    decode_byte(8'h00, 4'd7);
  endtask

  task automatic test_random_trees();
    int unsigned roll;
    int          inner;
    gaps_on = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 11);
      if (roll == 0)
        inner = 1;
      else if (roll == 1)
        inner = $urandom_range(24, 40);
      else
        inner = $urandom_range(2, 8);
      load_random_tree(inner);
      repeat ($urandom_range(6, 16)) begin
        if ($urandom_range(0, 7) == 0) stray_load();
        decode_byte(rand_byte(), pick_count());
      end
    end
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    load_random_tree(5);
    repeat (30) decode_byte(rand_byte(), pick_count());
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_symbols.size() == 0) begin
        report_mismatch($sformatf("unexpected symbol %02h", result.symbol));
      end else begin
        oldest_symbol = pending_symbols.pop_front();
        if (result.symbol !== oldest_symbol.symbol)
          report_mismatch($sformatf("symbol got %02h want %02h",
                                    result.symbol, oldest_symbol.symbol));
        if (result.last !== oldest_symbol.last)
          report_mismatch($sformatf("last got %b want %b on symbol %02h",
                                    result.last, oldest_symbol.last, oldest_symbol.symbol));
      end
    end
  end

  initial begin
    int waited;
    rst       = 1'b1;
    start     = 1'b0;
    command   = '0;
    walk_node = '0;
    gaps_on   = 1'b1;
    for (int i = 0; i < TABLE_DEPTH; i++) code_tree[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_boundary_tree();
    test_max_symbols_per_byte();
    test_beyond_table_walk();
    test_bit_count_saturation();
    test_random_trees();
    test_back_to_back();

    start <= 1'b0;
    for (waited = 0; waited < 1000 && pending_symbols.size() != 0; waited++)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_symbols.size() != 0)
      report_mismatch($sformatf("%0d symbols never delivered", pending_symbols.size()));
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
design/htwd_pkg.sv
design/htwd_ram.sv
design/htwd_walker.sv
design/huffman_tree_walk_decoder.sv
test/tb_top.sv
